### rtl/core/fcbs_pkg.sv
// shared types and constants for the frustum culling block
// no dependencies; used by the interfaces and every rtl module
`default_nettype none

package fcbs_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int PLANE_COUNT = 6;

	localparam int NUM_PLANES  = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int NRM_W       = 16;
	localparam int OFS_W       = 16;
	localparam int FRAC_SHIFT  = 14;
	localparam int RAD_W       = COORD_WIDTH - 1;
	localparam int PROD_W      = NRM_W + COORD_WIDTH;
	localparam int OFS_TERM_W  = OFS_W + FRAC_SHIFT;
	localparam int SUM_W       = ((PROD_W > OFS_TERM_W) ? PROD_W : OFS_TERM_W) + 3;

	typedef enum logic {
		OP_BOX    = 1'b0,
		OP_SPHERE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_LEFT   = 3'd0,
		REG_PLANE_RIGHT  = 3'd1,
		REG_PLANE_BOTTOM = 3'd2,
		REG_PLANE_TOP    = 3'd3,
		REG_PLANE_NEAR   = 3'd4,
		REG_PLANE_FAR    = 3'd5
	} reg_idx_t;

	// packed plane register: offset on top, normal x in the low bits
	typedef struct packed {
		logic signed [OFS_W-1:0] d;
		logic signed [NRM_W-1:0] nz;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nx;
	} plane_t;

endpackage

`default_nettype wire

### rtl/core/fcbs_if.sv
// valid/ready channel interfaces for volume items and culling results
// depends on fcbs_pkg
`default_nettype none

interface fcbs_item_if;
	logic                                   valid;
	logic                                   ready;
	fcbs_pkg::op_t                          opcode;
	logic signed [fcbs_pkg::COORD_WIDTH-1:0] point_x;
	logic signed [fcbs_pkg::COORD_WIDTH-1:0] point_y;
	logic signed [fcbs_pkg::COORD_WIDTH-1:0] point_z;
	logic signed [fcbs_pkg::COORD_WIDTH-1:0] box_max_x;
	logic signed [fcbs_pkg::COORD_WIDTH-1:0] box_max_y;
	logic signed [fcbs_pkg::COORD_WIDTH-1:0] box_max_z;
	logic        [fcbs_pkg::RAD_W-1:0]       radius;

	modport source (
		output valid, opcode, point_x, point_y, point_z,
		output box_max_x, box_max_y, box_max_z, radius,
		input  ready
	);
	modport sink (
		input  valid, opcode, point_x, point_y, point_z,
		input  box_max_x, box_max_y, box_max_z, radius,
		output ready
	);
endinterface

interface fcbs_result_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink   (input valid, visible, output ready);
endinterface

`default_nettype wire

### rtl/core/frustum_cull_box_sphere_top.sv
// top level of the frustum culling block: plane registers, lanes, result register
// depends on fcbs_pkg, fcbs_if, fcbs_cfg_regs and fcbs_lane
//
// usage
// - item channel (sink): one box (min/max corners) or sphere (centre, radius)
//   per transaction, opcode picks the test
// - result channel (source): one transaction per item carrying the visible bit,
//   results leave in the order items arrived
// - config port: cfg_we/cfg_index/cfg_data write one 64-bit plane register per
//   cycle, to be written only while no item is in flight; unmapped indexes are
//   dropped
// - pipeline: the product register in each lane, then the result register
// - throughput: one item per cycle while the receiver takes results, set by the
//   per-lane multipliers which all run in parallel, one lane for each plane
// - a stalled receiver holds the result register; the product stage still
//   takes a new item while it is empty, after that item.ready drops
// - reset clears the planes to zero (nothing is culled) and empties both stages
`default_nettype none

module frustum_cull_box_sphere_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	fcbs_item_if.sink                            item,
	fcbs_result_if.source                        result,
	input  wire logic                            cfg_we,
	input  wire logic [fcbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fcbs_pkg::CFG_DATA_W-1:0] cfg_data
);

	fcbs_pkg::plane_t [fcbs_pkg::NUM_PLANES-1:0] planes;

	logic                          v_s1;
	logic [fcbs_pkg::RAD_W-1:0]    rad_s1;
	logic                          res_valid_q;
	logic                          visible_q;
	logic                          adv_out;
	logic                          s1_en;
	logic [fcbs_pkg::PLANE_COUNT-1:0] cull;

	fcbs_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.planes (planes)
	);

	// stage control: result register moves when empty or taken,
	// the product stage moves when empty or when it can drain into the result
	assign adv_out    = !res_valid_q || result.ready;
	assign s1_en      = !v_s1 || adv_out;
	assign item.ready = s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= item.valid;
		end
	end

	// radius only counts for spheres, so a box sees a zero radius term
	always_ff @(posedge clk) begin
		if (s1_en && item.valid) begin
			rad_s1 <= (item.opcode == fcbs_pkg::OP_SPHERE) ? item.radius : '0;
		end
	end

	// one lane per tested plane
	for (genvar g = 0; g < fcbs_pkg::PLANE_COUNT; g++) begin : g_lane
		fcbs_lane u_lane (
			.clk       (clk),
			.en        (s1_en && item.valid),
			.plane     (planes[g]),
			.opcode    (item.opcode),
			.point_x   (item.point_x),
			.point_y   (item.point_y),
			.point_z   (item.point_z),
			.box_max_x (item.box_max_x),
			.box_max_y (item.box_max_y),
			.box_max_z (item.box_max_z),
			.rad_s1    (rad_s1),
			.cull      (cull[g])
		);
	end

	// result register: visible unless some plane culls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_out) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			visible_q <= ~|cull;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.visible = visible_q;

`ifndef NO_ASSERTIONS
	// an item held in the product stage reaches the result register when it may move
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_out |=> res_valid_q)
		else $error("product stage item lost on its way to the result register");

	// an accepted item always lands in the product stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> v_s1)
		else $error("accepted item missing from the product stage");

	// backpressure only when both stages are full and the receiver stalls
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (v_s1 && res_valid_q && !result.ready))
		else $error("item channel stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

### rtl/core/fcbs_cfg_regs.sv
// plane register file written through the plain configuration port
// depends on fcbs_pkg
`default_nettype none

module fcbs_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                we,
	input  wire logic [fcbs_pkg::CFG_IDX_W-1:0]      index,
	input  wire logic [fcbs_pkg::CFG_DATA_W-1:0]     data,
	output fcbs_pkg::plane_t [fcbs_pkg::NUM_PLANES-1:0] planes
);

	fcbs_pkg::plane_t [fcbs_pkg::NUM_PLANES-1:0] planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (we) begin
			unique case (fcbs_pkg::reg_idx_t'(index))
				fcbs_pkg::REG_PLANE_LEFT:   planes_q[0] <= fcbs_pkg::plane_t'(data);
				fcbs_pkg::REG_PLANE_RIGHT:  planes_q[1] <= fcbs_pkg::plane_t'(data);
				fcbs_pkg::REG_PLANE_BOTTOM: planes_q[2] <= fcbs_pkg::plane_t'(data);
				fcbs_pkg::REG_PLANE_TOP:    planes_q[3] <= fcbs_pkg::plane_t'(data);
				fcbs_pkg::REG_PLANE_NEAR:   planes_q[4] <= fcbs_pkg::plane_t'(data);
				fcbs_pkg::REG_PLANE_FAR:    planes_q[5] <= fcbs_pkg::plane_t'(data);
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign planes = planes_q;

endmodule

`default_nettype wire

### rtl/core/fcbs_lane.sv
// one plane lane: corner select and products, registered, then distance sign
// depends on fcbs_pkg
`default_nettype none

module fcbs_lane (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire fcbs_pkg::plane_t                      plane,
	input  wire fcbs_pkg::op_t                         opcode,
	input  wire logic signed [fcbs_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [fcbs_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic signed [fcbs_pkg::COORD_WIDTH-1:0] point_z,
	input  wire logic signed [fcbs_pkg::COORD_WIDTH-1:0] box_max_x,
	input  wire logic signed [fcbs_pkg::COORD_WIDTH-1:0] box_max_y,
	input  wire logic signed [fcbs_pkg::COORD_WIDTH-1:0] box_max_z,
	input  wire logic        [fcbs_pkg::RAD_W-1:0]       rad_s1,
	output logic                                       cull
);

	logic signed [fcbs_pkg::COORD_WIDTH-1:0] px, py, pz;
	logic signed [fcbs_pkg::PROD_W-1:0]      prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [fcbs_pkg::SUM_W-1:0]       ofs_term, rad_term, dist_sum;
	logic                                    is_box;

	// box: take the maximum where the normal component is non-negative
	assign is_box = (opcode == fcbs_pkg::OP_BOX);
	assign px = (is_box && !plane.nx[fcbs_pkg::NRM_W-1]) ? box_max_x : point_x;
	assign py = (is_box && !plane.ny[fcbs_pkg::NRM_W-1]) ? box_max_y : point_y;
	assign pz = (is_box && !plane.nz[fcbs_pkg::NRM_W-1]) ? box_max_z : point_z;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= fcbs_pkg::PROD_W'(plane.nx) * fcbs_pkg::PROD_W'(px);
			prod_y_s1 <= fcbs_pkg::PROD_W'(plane.ny) * fcbs_pkg::PROD_W'(py);
			prod_z_s1 <= fcbs_pkg::PROD_W'(plane.nz) * fcbs_pkg::PROD_W'(pz);
		end
	end

	// offset and radius aligned to 14 fraction bits; radius is zero for boxes
	assign ofs_term = fcbs_pkg::SUM_W'(plane.d) <<< fcbs_pkg::FRAC_SHIFT;
	assign rad_term = signed'(fcbs_pkg::SUM_W'(rad_s1)) <<< fcbs_pkg::FRAC_SHIFT;

	assign dist_sum = fcbs_pkg::SUM_W'(prod_x_s1) + fcbs_pkg::SUM_W'(prod_y_s1)
		+ fcbs_pkg::SUM_W'(prod_z_s1) + ofs_term + rad_term;

	assign cull = dist_sum[fcbs_pkg::SUM_W-1];

endmodule

`default_nettype wire
